>>> hdl/display_packet_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// display_packet_receiver_top_assert.svh
// Assertion macros used by the display packet receiver frame module.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_PACKET_RECEIVER_TOP_ASSERT_SVH
`define DISPLAY_PACKET_RECEIVER_TOP_ASSERT_SVH

// Checked on every rising edge outside reset
`define DPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define DPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Constants, types and result layout of the display packet receiver.
// ----------------------------------------------------------------------------
package dpr_pkg;

  // Frame geometry
  localparam int FRAME_LENGTH = 12;
  localparam int CNT_W        = 4;

  // Sync bytes, checksum key and speed offset
  localparam logic [7:0] SYNC_FIRST  = 8'd50;
  localparam logic [7:0] SYNC_SECOND = 8'd14;
  localparam logic [7:0] CHECK_KEY   = 8'd9;
  localparam logic [6:0] SPEED_OFFSET = 7'd10;

  // Byte positions inside a frame
  localparam logic [CNT_W-1:0] IDX_LEVEL   = CNT_W'(3);
  localparam logic [CNT_W-1:0] IDX_SPEED   = CNT_W'(4);
  localparam logic [CNT_W-1:0] IDX_MOTOR   = CNT_W'(5);
  localparam logic [CNT_W-1:0] IDX_WHEEL   = CNT_W'(6);
  localparam logic [CNT_W-1:0] IDX_CHECK   = CNT_W'(7);
  localparam logic [CNT_W-1:0] IDX_CURRENT = CNT_W'(9);
  localparam logic [CNT_W:0]   LAST_COUNT  = (CNT_W+1)'(FRAME_LENGTH);

  // Receiver sync phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SECOND  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  // One decoded frame
  typedef struct packed {
    logic       checksum_ok;
    logic [2:0] assist_level;
    logic [7:0] motor_characteristic;
    logic [4:0] wheel_size_code;
    logic [6:0] max_speed;
    logic       assist_mode;
    logic [3:0] max_current_code;
  } result_t;

endpackage

>>> hdl/display_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// display_packet_receiver_top
// Display link frame receiver with sync hunt and XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel: one received serial byte per beat (valid/ready).
//   out_ channel: one beat per complete frame, carrying the checksum flag
//   and the unpacked settings; a bad checksum still yields a beat with
//   out_checksum_ok low.
//   A frame is the byte 50, the byte 14 and the remaining bytes up to the
//   frame length; a wrong second sync byte is dropped and hunting resumes.
// Timing:
//   A byte passes an input register and the frame logic, and the result is
//   registered in the result register. One byte is taken every cycle while
//   the result register is empty or its beat is being taken.
// Reset: rst_n (synchronous, active low) empties both registers and
//   returns the receiver to hunting for the first sync byte.
// Stall: while out_ready is low and a result waits, in_ready drops once
//   the input register is also occupied; no beat is lost.
// ----------------------------------------------------------------------------
module display_packet_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_checksum_ok,
  output logic [2:0] out_assist_level,
  output logic [7:0] out_motor_characteristic,
  output logic [4:0] out_wheel_size_code,
  output logic [6:0] out_max_speed,
  output logic       out_assist_mode,
  output logic [3:0] out_max_current_code
);

  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             take;
  logic             advance;
  logic             res_valid;
  dpr_pkg::result_t res;
  dpr_pkg::result_t out_res;

  dpr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  dpr_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .advance    (advance),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  dpr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Result fields onto their ports
  assign out_checksum_ok          = out_res.checksum_ok;
  assign out_assist_level         = out_res.assist_level;
  assign out_motor_characteristic = out_res.motor_characteristic;
  assign out_wheel_size_code      = out_res.wheel_size_code;
  assign out_max_speed            = out_res.max_speed;
  assign out_assist_mode          = out_res.assist_mode;
  assign out_max_current_code     = out_res.max_current_code;

endmodule

>>> hdl/dpr_in_reg.sv
// ----------------------------------------------------------------------------
// dpr_in_reg
// Input register: holds one received byte until the frame stage takes it.
// ----------------------------------------------------------------------------
module dpr_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] hold_data_r;
  logic       load;

  // Free when empty or when the held beat leaves this cycle
  assign in_ready = !hold_valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (load) begin
      hold_valid_nxt = 1'b1;
    end else if (take) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      hold_data_r <= in_rx_byte;
    end
  end

  assign byte_valid = hold_valid_r;
  assign byte_data  = hold_data_r;

endmodule

>>> hdl/dpr_frame.sv
// ----------------------------------------------------------------------------
// dpr_frame
// Sync hunt, frame assembly, running checksum and field unpacking.
// ----------------------------------------------------------------------------
`include "display_packet_receiver_top_assert.svh"

module dpr_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  input  logic              advance,
  output logic              take,
  output logic              res_valid,
  output dpr_pkg::result_t  res
);

  dpr_pkg::phase_t             phase_r, phase_nxt;
  logic [dpr_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic [7:0]                  b3_r, b4_r, b5_r, b6_r, b7_r, b9_r;
  logic [7:0]                  b3, b4, b5, b6, b7, b9;
  logic [7:0]                  xor_store;
  logic                        store;
  logic                        last;

  assign take = byte_valid && advance;

  // Checksum and end-of-frame test for the byte being stored
  assign xor_store = (count_r != dpr_pkg::IDX_CHECK) ? (xor_r ^ byte_data) : xor_r;
  assign last      = ({1'b0, count_r} + 1'b1) >= dpr_pkg::LAST_COUNT;

  // Next phase, count and checksum
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    store     = 1'b0;
    res_valid = 1'b0;
    unique case (phase_r)
      dpr_pkg::PH_SECOND: begin
        if (byte_data == dpr_pkg::SYNC_SECOND) begin
          store     = 1'b1;
          phase_nxt = dpr_pkg::PH_COLLECT;
          count_nxt = count_r + 1'b1;
          xor_nxt   = xor_store;
        end else begin
          phase_nxt = dpr_pkg::PH_HUNT;
          count_nxt = '0;
          xor_nxt   = '0;
        end
      end
      dpr_pkg::PH_COLLECT: begin
        store = 1'b1;
        if (last) begin
          res_valid = byte_valid;
          phase_nxt = dpr_pkg::PH_HUNT;
          count_nxt = '0;
          xor_nxt   = '0;
        end else begin
          count_nxt = count_r + 1'b1;
          xor_nxt   = xor_store;
        end
      end
      default: begin
        // hunting; a leftover code counts as hunting
        if (byte_data == dpr_pkg::SYNC_FIRST) begin
          store     = 1'b1;
          phase_nxt = dpr_pkg::PH_SECOND;
          count_nxt = dpr_pkg::CNT_W'(1);
          xor_nxt   = byte_data;
        end else begin
          phase_nxt = dpr_pkg::PH_HUNT;
          count_nxt = '0;
          xor_nxt   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dpr_pkg::PH_HUNT;
      count_r <= '0;
      xor_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // Capture only the frame bytes that carry settings or the checksum
  always_ff @(posedge clk) begin
    if (take && store) begin
      if (count_r == dpr_pkg::IDX_LEVEL)   b3_r <= byte_data;
      if (count_r == dpr_pkg::IDX_SPEED)   b4_r <= byte_data;
      if (count_r == dpr_pkg::IDX_MOTOR)   b5_r <= byte_data;
      if (count_r == dpr_pkg::IDX_WHEEL)   b6_r <= byte_data;
      if (count_r == dpr_pkg::IDX_CHECK)   b7_r <= byte_data;
      if (count_r == dpr_pkg::IDX_CURRENT) b9_r <= byte_data;
    end
  end

  // The final byte may itself be one of the settings bytes on short frames
  assign b3 = (count_r == dpr_pkg::IDX_LEVEL)   ? byte_data : b3_r;
  assign b4 = (count_r == dpr_pkg::IDX_SPEED)   ? byte_data : b4_r;
  assign b5 = (count_r == dpr_pkg::IDX_MOTOR)   ? byte_data : b5_r;
  assign b6 = (count_r == dpr_pkg::IDX_WHEEL)   ? byte_data : b6_r;
  assign b7 = (count_r == dpr_pkg::IDX_CHECK)   ? byte_data : b7_r;
  assign b9 = (count_r == dpr_pkg::IDX_CURRENT) ? byte_data : b9_r;

  // Unpack the settings
  always_comb begin
    res.checksum_ok          = ((xor_store ^ dpr_pkg::CHECK_KEY) == b7);
    res.assist_level         = b3[2:0];
    res.motor_characteristic = b5;
    res.wheel_size_code      = {b4[2:0], b6[7:6]};
    res.max_speed            = dpr_pkg::SPEED_OFFSET + {1'b0, b6[5], b4[7:3]};
    res.assist_mode          = b6[3];
    res.max_current_code     = b9[3:0];
  end

  // Checks
  `DPR_ASSERT(a_res_in_collect, res_valid |-> (phase_r == dpr_pkg::PH_COLLECT), "result outside collect phase")
  `DPR_ASSERT(a_restart_after_frame, (take && res_valid) |=> (phase_r == dpr_pkg::PH_HUNT && count_r == '0 && xor_r == '0), "no restart after frame end")
  `DPR_ASSERT(a_second_after_first, (phase_r == dpr_pkg::PH_SECOND) |-> (count_r == dpr_pkg::CNT_W'(1) && xor_r == dpr_pkg::SYNC_FIRST), "bad state while expecting second sync")
  `DPR_ASSERT(a_collect_count, (phase_r == dpr_pkg::PH_COLLECT) |-> (count_r >= dpr_pkg::CNT_W'(2) && ({1'b0, count_r} < dpr_pkg::LAST_COUNT)), "frame count out of range")

endmodule

>>> hdl/dpr_out_reg.sv
// ----------------------------------------------------------------------------
// dpr_out_reg
// Result register: holds one decoded frame until the receiver takes it.
// ----------------------------------------------------------------------------
module dpr_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  dpr_pkg::result_t res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output dpr_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  dpr_pkg::result_t res_r;

  // Register may load when empty or when its beat is taken now
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
